/* rtl/aedm_pkg.sv */
// package for the audio echo delay mixer
// holds sequencer states, command and status structs, register codes and reset values
// no dependencies
`default_nettype none

package aedm_pkg;

    localparam int unsigned MAX_DELAY_DEF = 8192;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned DELAY_W  = 14;
    localparam int unsigned VOLUME_W = 8;
    localparam int unsigned APB_AW   = 3;
    localparam int unsigned APB_DW   = 32;

    localparam logic [DELAY_W-1:0]  DELAY_RESET  = 14'd8000;
    localparam logic [VOLUME_W-1:0] VOLUME_RESET = 8'd4;

    // register index taken from the word address
    localparam logic REG_DELAY  = 1'b0;
    localparam logic REG_VOLUME = 1'b1;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    // serial divider: one quotient bit per cycle
    localparam int unsigned DIV_STEPS = SAMPLE_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_LOAD,
        S_DIV,
        S_MIX,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic load;        // capture input word
        logic fill_write;  // pass-through and store at position
        logic read;        // fetch delayed sample
        logic div_start;
        logic div_step;
        logic mix;         // add echo, replace ring entry, advance pointer
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic fill;
        logic div_last;
    } status_t;

endpackage

`default_nettype wire

/* rtl/aedm_ctrl.sv */
// sequencer for the audio echo delay mixer
// drives datapath commands and owns the input ready and output valid handshakes
// depends on aedm_pkg
`default_nettype none

module aedm_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire aedm_pkg::status_t status,
    output aedm_pkg::cmd_t         cmd
);

    aedm_pkg::state_t state_reg;
    aedm_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            aedm_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = aedm_pkg::S_CHECK;
            end
            aedm_pkg::S_CHECK:
            begin
                if (status.fill)
                    state_next = aedm_pkg::S_RESULT;
                else
                    state_next = aedm_pkg::S_LOAD;
            end
            aedm_pkg::S_LOAD:
                state_next = aedm_pkg::S_DIV;
            aedm_pkg::S_DIV:
            begin
                if (status.div_last)
                    state_next = aedm_pkg::S_MIX;
            end
            aedm_pkg::S_MIX:
                state_next = aedm_pkg::S_RESULT;
            aedm_pkg::S_RESULT:
            begin
                if (slot_free)
                    state_next = aedm_pkg::S_IDLE;
            end
            default:
                state_next = aedm_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            aedm_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            aedm_pkg::S_CHECK:
            begin
                cmd.fill_write = status.fill;
                cmd.read       = !status.fill;
            end
            aedm_pkg::S_LOAD:
                cmd.div_start = 1'b1;
            aedm_pkg::S_DIV:
                cmd.div_step = 1'b1;
            aedm_pkg::S_MIX:
                cmd.mix = 1'b1;
            aedm_pkg::S_RESULT:
                cmd.out_load = slot_free;
            default:
                cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aedm_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // a new result never lands on a word still waiting to be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending output word");

    // the last divide step hands over to the mix
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == aedm_pkg::S_DIV && status.div_last) |=> state_reg == aedm_pkg::S_MIX)
        else $error("divider finish not followed by mix");

    // output word only goes away when taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(out_ready))
        else $error("output word dropped without being taken");

endmodule

`default_nettype wire

/* rtl/aedm_datapath.sv */
// datapath for the audio echo delay mixer
// echo ring memory, position and pointer counters, serial divider and mixer
// depends on aedm_pkg
`default_nettype none

module aedm_datapath
#(
    parameter int unsigned MAX_DELAY = aedm_pkg::MAX_DELAY_DEF
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire aedm_pkg::cmd_t                       cmd,
    output aedm_pkg::status_t                         status,
    input  wire logic                                 op,
    input  wire logic signed [aedm_pkg::SAMPLE_W-1:0] sample_in,
    input  wire logic [aedm_pkg::DELAY_W-1:0]         delay_samples,
    input  wire logic [aedm_pkg::VOLUME_W-1:0]        volume_divisor,
    output logic signed [aedm_pkg::SAMPLE_W-1:0]      sample_out
);

    localparam int unsigned SW = aedm_pkg::SAMPLE_W;
    localparam int unsigned VW = aedm_pkg::VOLUME_W;
    localparam int unsigned AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int unsigned PW = $clog2(MAX_DELAY + 1);
    localparam int unsigned EW = (PW > aedm_pkg::DELAY_W) ? PW : aedm_pkg::DELAY_W;

    logic [SW-1:0] ring_mem [MAX_DELAY];

    logic [SW-1:0] x_reg;
    logic [PW-1:0] pos_reg;
    logic [AW-1:0] ptr_reg;
    logic [SW-1:0] rd_data_reg;
    logic [SW-1:0] dq_reg;
    logic [VW-1:0] rem_reg;
    logic          neg_reg;
    logic [aedm_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [SW-1:0] res_reg;
    logic [SW-1:0] out_reg;

    logic [EW-1:0] delay_ext;
    logic [EW-1:0] delay_sat;
    logic [PW-1:0] d_eff;
    logic [VW-1:0] div_eff;
    logic [AW-1:0] ptr_use;
    logic [PW-1:0] ptr_inc;
    logic [VW:0]   trial;
    logic          ge;
    logic [SW-1:0] mag;
    logic [SW-1:0] quot;

    // delay of zero acts as one, larger than the ring saturates
    always_comb
    begin
        delay_ext = EW'(delay_samples);
        if (delay_samples == '0)
            delay_sat = EW'(1);
        else if (delay_ext > EW'(MAX_DELAY))
            delay_sat = EW'(MAX_DELAY);
        else
            delay_sat = delay_ext;
    end

    assign d_eff   = PW'(delay_sat);
    assign div_eff = (volume_divisor == '0) ? VW'(1) : volume_divisor;

    assign status.fill     = pos_reg < d_eff;
    assign status.div_last = cnt_reg == aedm_pkg::DIV_LAST;

    // pointer restarts when the delay was lowered under it
    assign ptr_use = (PW'(ptr_reg) >= d_eff) ? '0 : ptr_reg;
    assign ptr_inc = PW'(ptr_reg) + PW'(1);

    assign trial = {rem_reg, dq_reg[SW-1]};
    assign ge    = trial >= {1'b0, div_eff};
    assign mag   = rd_data_reg[SW-1] ? (~rd_data_reg + SW'(1)) : rd_data_reg;
    assign quot  = neg_reg ? (~dq_reg + SW'(1)) : dq_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.fill_write)
            ring_mem[pos_reg[AW-1:0]] <= x_reg;
        else if (cmd.mix)
            ring_mem[ptr_reg] <= x_reg;
        if (cmd.read)
            rd_data_reg <= ring_mem[ptr_use];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cmd.fill_write)
                pos_reg <= pos_reg + PW'(1);
            else if (cmd.mix)
                pos_reg <= d_eff;

            if (cmd.read)
                ptr_reg <= ptr_use;
            else if (cmd.mix)
                ptr_reg <= (ptr_inc >= d_eff) ? '0 : AW'(ptr_inc);

            if (cmd.div_start)
                cnt_reg <= '0;
            else if (cmd.div_step)
                cnt_reg <= cnt_reg + aedm_pkg::DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            x_reg <= (op == aedm_pkg::OP_DRAIN) ? '0 : sample_in;

        // restoring divide on the magnitude, sign put back afterwards
        if (cmd.div_start)
        begin
            dq_reg  <= mag;
            rem_reg <= '0;
            neg_reg <= rd_data_reg[SW-1];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? VW'(trial - {1'b0, div_eff}) : trial[VW-1:0];
            dq_reg  <= {dq_reg[SW-2:0], ge};
        end

        if (cmd.fill_write)
            res_reg <= x_reg;
        else if (cmd.mix)
            res_reg <= x_reg + quot;

        if (cmd.out_load)
            out_reg <= res_reg;
    end

    assign sample_out = out_reg;

    // fill phase only when the position is still below the delay
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_write |-> status.fill)
        else $error("pass-through write outside the fill phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_write |=> pos_reg == $past(pos_reg) + PW'(1))
        else $error("position did not advance on a fill word");

    // pointer always lands inside the ring length in use
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mix |=> PW'(ptr_reg) < d_eff)
        else $error("ring pointer beyond the delay after mix");

endmodule

`default_nettype wire

/* rtl/audio_echo_delay_mixer.sv */
// audio echo delay mixer: in the fill phase an accepted word passes through the check and result
// states; once the echo is mixed in it also runs the load, bit-serial divide and mix states
// one word is handled at a time, held up by the serial divider: a new input word is taken only
// after the last result is loaded, which waits while the previous output word is not taken
// reset clears the sequencer, position and pointer and sets delay 8000, divisor 4;
// the echo ring is not cleared and no clearing pass runs
`default_nettype none

module audio_echo_delay_mixer
#(
    parameter int unsigned MAX_DELAY = aedm_pkg::MAX_DELAY_DEF
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [aedm_pkg::APB_AW-1:0]          paddr,
    input  wire logic [aedm_pkg::APB_DW-1:0]          pwdata,
    output logic [aedm_pkg::APB_DW-1:0]               prdata,
    output logic                                      pready,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic                                 op,
    input  wire logic signed [aedm_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [aedm_pkg::SAMPLE_W-1:0]      sample_out
);

    logic [aedm_pkg::DELAY_W-1:0]  delay_reg;
    logic [aedm_pkg::VOLUME_W-1:0] volume_reg;
    logic                          wr_en;
    logic                          reg_sel;
    aedm_pkg::cmd_t                cmd;
    aedm_pkg::status_t             status;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg  <= aedm_pkg::DELAY_RESET;
            volume_reg <= aedm_pkg::VOLUME_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                aedm_pkg::REG_DELAY:  delay_reg  <= pwdata[aedm_pkg::DELAY_W-1:0];
                aedm_pkg::REG_VOLUME: volume_reg <= pwdata[aedm_pkg::VOLUME_W-1:0];
                default:              delay_reg  <= delay_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            aedm_pkg::REG_DELAY:  prdata = aedm_pkg::APB_DW'(delay_reg);
            aedm_pkg::REG_VOLUME: prdata = aedm_pkg::APB_DW'(volume_reg);
            default:              prdata = '0;
        endcase
    end

    aedm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    aedm_datapath
    #(
        .MAX_DELAY (MAX_DELAY)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .op             (op),
        .sample_in      (sample_in),
        .delay_samples  (delay_reg),
        .volume_divisor (volume_reg),
        .sample_out     (sample_out)
    );

endmodule

`default_nettype wire

/* tb/echo_mix_checker.sv */
// checker for the audio echo delay mixer: follows register writes on the config port,
// predicts every output word from the accepted input words and compares them in order
// depends on aedm_pkg
`default_nettype none

module echo_mix_checker
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic                                 pready,
    input  wire logic [aedm_pkg::APB_AW-1:0]          paddr,
    input  wire logic [aedm_pkg::APB_DW-1:0]          pwdata,
    input  wire logic                                 in_valid,
    input  wire logic                                 in_ready,
    input  wire logic                                 op,
    input  wire logic signed [aedm_pkg::SAMPLE_W-1:0] sample_in,
    input  wire logic                                 out_valid,
    input  wire logic                                 out_ready,
    input  wire logic signed [aedm_pkg::SAMPLE_W-1:0] sample_out,
    output int                                        mismatch_count,
    output int                                        pending_words
);
    import aedm_pkg::*;

    localparam int unsigned RING_DEPTH = MAX_DELAY_DEF;
    localparam int          REPORT_MAX = 10;

    logic [DELAY_W-1:0]  delay_reg;
    logic [VOLUME_W-1:0] volume_reg;
    logic [SAMPLE_W-1:0] echo_mem [RING_DEPTH];
    int unsigned         fill_pos;
    int unsigned         tap;
    logic [SAMPLE_W-1:0] mixed_q [$];

    // next output word; updates the echo memory, fill position and tap
    function automatic logic [SAMPLE_W-1:0] mix_next(input logic kind,
                                                     input logic signed [SAMPLE_W-1:0] s);
        int unsigned         span;
        int                  divisor;
        int                  x;
        int                  echo;
        logic [SAMPLE_W-1:0] y;
        span = (delay_reg == '0) ? 1 : int'(delay_reg);
        if (span > RING_DEPTH)
            span = RING_DEPTH;
        divisor = (volume_reg == '0) ? 1 : int'(volume_reg);
        x = (kind == OP_DRAIN) ? 0 : int'(s);
        if (fill_pos < span)
        begin
            echo_mem[fill_pos] = SAMPLE_W'(x);
            y = SAMPLE_W'(x);
            fill_pos++;
        end
        else
        begin
            // a tap left beyond a lowered delay starts over
            if (tap >= span)
                tap = 0;
            echo = int'($signed(echo_mem[tap]));
            y = SAMPLE_W'(x + echo / divisor);
            echo_mem[tap] = SAMPLE_W'(x);
            tap++;
            if (tap >= span)
                tap = 0;
            fill_pos = span;
        end
        return y;
    endfunction

    initial
    begin
        mismatch_count = 0;
        pending_words  = 0;
        for (int i = 0; i < RING_DEPTH; i++)
            echo_mem[i] = '0;
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [SAMPLE_W-1:0] want;
        if (!rst_n)
        begin
            delay_reg  = DELAY_RESET;
            volume_reg = VOLUME_RESET;
            fill_pos   = 0;
            tap        = 0;
            mixed_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_DELAY)
                    delay_reg = pwdata[DELAY_W-1:0];
                else
                    volume_reg = pwdata[VOLUME_W-1:0];
            end
            if (in_valid && in_ready)
                mixed_q.push_back(mix_next(op, sample_in));
            if (out_valid && out_ready)
            begin
                if (mixed_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: output word %0d with no word expected",
                                 $time, sample_out);
                end
                else
                begin
                    want = mixed_q.pop_front();
                    if (sample_out !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("%0t: sample_out expected %0d got %0d",
                                     $time, $signed(want), sample_out);
                    end
                end
            end
        end
        pending_words = mixed_q.size();
    end

endmodule

`default_nettype wire

/* tb/audio_echo_delay_mixer_tb.sv */
// testbench top for the audio echo delay mixer: clock, reset, register writes, sample and
// drain word stimulus with random idling on both sides, watchdog and verdict
// depends on aedm_pkg, audio_echo_delay_mixer and echo_mix_checker
`default_nettype none

module audio_echo_delay_mixer_tb;
    import aedm_pkg::*;

    localparam logic [APB_AW-1:0] ADDR_DELAY  = {REG_DELAY, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_VOLUME = {REG_VOLUME, 2'b00};

    localparam int SEGMENTS    = 9;
    localparam int SEG_WORDS   = 91;
    localparam int MAX_CLIP    = 60;
    localparam int MAX_DRAINS  = 30;
    localparam int HOLD_OFF    = 400;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 40;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [APB_AW-1:0]          paddr;
    logic [APB_DW-1:0]          pwdata;
    logic [APB_DW-1:0]          prdata;
    logic                       pready;
    logic                       in_valid;
    logic                       in_ready;
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    int          mismatch_count;
    int          pending_words;
    int          send_idle_pct = 19;
    int          recv_idle_pct = 85;
    logic        hold_off_req  = 1'b0;
    int unsigned cur_delay;

    audio_echo_delay_mixer u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out)
    );

    echo_mix_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .sample_in      (sample_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sample_out     (sample_out),
        .mismatch_count (mismatch_count),
        .pending_words  (pending_words)
    );

    always #2 clk = ~clk;

    task automatic reg_write(input logic [APB_AW-1:0] addr, input int unsigned value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= APB_DW'(value);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stop offering words and wait until every predicted word has come out
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_words != 0)
            @(negedge clk);
    endtask

    task automatic configure(input int unsigned delay_val, input int unsigned volume_val);
        settle();
        reg_write(ADDR_DELAY, delay_val);
        reg_write(ADDR_VOLUME, volume_val);
        cur_delay = (delay_val == 0) ? 1 :
                    (delay_val > MAX_DELAY_DEF) ? MAX_DELAY_DEF : delay_val;
    endtask

    task automatic send_word(input logic kind, input logic signed [SAMPLE_W-1:0] value);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        op        <= kind;
        sample_in <= value;
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(15))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial
    begin : receiver
        int held;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            // long hold-off so the block backs up and stalls its input
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                for (held = 0; held < HOLD_OFF; held++)
                    @(negedge clk);
                hold_off_req = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL audio_echo_delay_mixer");
        $finish;
    end

    initial
    begin : stimulus
        int   seg;
        int   sent;
        int   samples;
        int   drains;
        int   i;
        int unsigned seg_delay;
        int unsigned seg_volume;
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        op        = OP_SAMPLE;
        sample_in = '0;
        cur_delay = DELAY_RESET;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings, still filling: words pass straight through
        send_word(OP_SAMPLE, 16'sh7FFF);
        send_word(OP_SAMPLE, 16'sh8000);
        send_word(OP_SAMPLE, 16'shFFFF);
        send_word(OP_DRAIN, 16'sh5A5A);
        send_word(OP_SAMPLE, 16'sh0001);

        // delay lowered below the position: echo mixes in at once, full-scale sums wrap
        configure(3, 1);
        send_word(OP_SAMPLE, 16'sh7FFF);
        send_word(OP_SAMPLE, 16'sh8000);
        send_word(OP_SAMPLE, 16'sh0000);
        repeat (4) send_word(OP_DRAIN, 16'shFFFF);

        // zero delay and zero divisor both act as one
        configure(0, 0);
        send_word(OP_SAMPLE, 16'sh4000);
        send_word(OP_SAMPLE, 16'shFFFB);
        repeat (2) send_word(OP_DRAIN, 16'sh0000);

        // delay past the ring size saturates, fill resumes at the current position
        configure(16383, 255);
        send_word(OP_SAMPLE, 16'sh1234);
        send_word(OP_SAMPLE, 16'sh8000);
        send_word(OP_SAMPLE, 16'sh7FFF);

        configure(2, 255);
        send_word(OP_SAMPLE, 16'sh8000);
        send_word(OP_SAMPLE, 16'sh7FFF);
        repeat (2) send_word(OP_DRAIN, 16'sh8000);

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg / 3)
                0:
                begin
                    send_idle_pct = 19;
                    recv_idle_pct = 85;
                end
                1:
                begin
                    send_idle_pct = 85;
                    recv_idle_pct = 19;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            seg_delay  = (seg == 3) ? 0 : (seg == 4) ? 16383 : $urandom_range(1, 48);
            seg_volume = (seg == 1) ? 255 : (seg == 2) ? 1 : (seg == 5) ? 0 :
                         $urandom_range(2, 254);
            configure(seg_delay, seg_volume);
            if (seg == 6)
                hold_off_req = 1'b1;

            // clips of audio followed by their drain tail, some tails cut or overrun
            sent = 0;
            while (sent < SEG_WORDS)
            begin
                samples = $urandom_range(1, (3 * cur_delay < MAX_CLIP) ? 3 * cur_delay
                                                                        : MAX_CLIP);
                drains  = (cur_delay < MAX_DRAINS) ? cur_delay : MAX_DRAINS;
                case ($urandom_range(9))
                    0:       drains = $urandom_range(0, drains);
                    1:       drains = drains + $urandom_range(1, 4);
                    default: ;
                endcase
                for (i = 0; i < samples; i++)
                    send_word(($urandom_range(19) == 0) ? OP_DRAIN : OP_SAMPLE,
                              pick_sample());
                for (i = 0; i < drains; i++)
                    send_word(OP_DRAIN, SAMPLE_W'($urandom));
                sent += samples + drains;
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && pending_words == 0)
            $display("PASS audio_echo_delay_mixer");
        else
            $display("FAIL audio_echo_delay_mixer");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
rtl/aedm_pkg.sv
rtl/aedm_ctrl.sv
rtl/aedm_datapath.sv
rtl/audio_echo_delay_mixer.sv
tb/echo_mix_checker.sv
tb/audio_echo_delay_mixer_tb.sv
